>>> src/keyboard_scancode_decoder_fifo_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard scancode decoder
// Shared clocked forms with reset disable.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_DECODER_FIFO_TOP_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define KSCDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define KSCDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kscdf_pkg.sv
// ----------------------------------------------------------------------------
// kscdf_pkg
// Scancode constants, key tables and shared types for the decoder.
// ----------------------------------------------------------------------------
package kscdf_pkg;

  // Default ring size (holds one entry fewer than this)
  localparam int unsigned QUEUE_DEPTH_DEF = 256;

  // Output buffer sizing
  localparam int unsigned OB_DEPTH = 4;
  localparam int unsigned OB_PTR_W = 2;
  localparam int unsigned OB_CNT_W = 3;

  // Operation codes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Scancodes with special meaning
  localparam logic [7:0] SC_PREFIX   = 8'hE0;
  localparam logic [7:0] SC_ALT_MK   = 8'h38;
  localparam logic [7:0] SC_ALT_BRK  = 8'hB8;
  localparam logic [7:0] SC_CTRL_MK  = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK = 8'h9D;
  localparam logic [7:0] SC_LSH_MK   = 8'h2A;
  localparam logic [7:0] SC_LSH_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSH_MK   = 8'h36;
  localparam logic [7:0] SC_RSH_BRK  = 8'hB6;
  localparam logic [7:0] SC_CAPS_MK  = 8'h3A;
  localparam logic [7:0] SC_CAPS_BRK = 8'hBA;
  localparam logic [7:0] SC_DELETE   = 8'h53;
  localparam logic [7:0] SC_LAST_KEY = 8'h39;

  localparam logic [1:0] PREFIX_LOAD = 2'd2;
  localparam logic [7:0] CH_DELETE   = 8'h7F;
  localparam logic [7:0] CTRL_MASK   = 8'h1F;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  localparam int unsigned TAB_N = 58;

  localparam logic [7:0] PLAIN_TAB [TAB_N] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h80,
    8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
    8'h2C, 8'h2E, 8'h2F, 8'h80,
    8'h2A, 8'h80, 8'h20
  };

  localparam logic [7:0] SHIFT_TAB [TAB_N] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h80,
    8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
    8'h3C, 8'h3E, 8'h3F, 8'h80,
    8'h2A, 8'h80, 8'h20
  };

  // Character push from the decoder into the ring
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } push_t;

  // One result beat
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_char;
    logic       reset_request;
    logic       key_dropped;
  } result_t;

  // Table lookup; Delete gives the same code in both tables
  function automatic logic [7:0] kscdf_lookup(input logic shifted, input logic [7:0] code);
    logic [7:0] val;
    val = 8'h00;
    if (code == SC_DELETE) begin
      val = CH_DELETE;
    end else if (code <= SC_LAST_KEY) begin
      val = shifted ? SHIFT_TAB[code[5:0]] : PLAIN_TAB[code[5:0]];
    end
    return val;
  endfunction

endpackage

>>> src/kscdf_decode.sv
// ----------------------------------------------------------------------------
// kscdf_decode
// Modifier flags, extended-prefix counter and scancode translation.
// ----------------------------------------------------------------------------
module kscdf_decode import kscdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       scan_i,
  input  logic [7:0] scancode_i,
  output push_t      push_o,
  output logic       reset_req_o
);

  logic       alt_q, alt_d;
  logic       ctrl_q, ctrl_d;
  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic [1:0] pc_q, pc_d;
  logic [1:0] pc_dec;
  logic       translate;
  logic [7:0] base;
  logic [7:0] ch;

  // Flag and prefix update
  always_comb begin
    pc_dec      = (pc_q != 2'd0) ? (pc_q - 2'd1) : pc_q;
    alt_d       = alt_q;
    ctrl_d      = ctrl_q;
    shift_d     = shift_q;
    caps_d      = caps_q;
    pc_d        = pc_q;
    translate   = 1'b0;
    reset_req_o = 1'b0;
    if (scan_i) begin
      pc_d = pc_dec;
      case (scancode_i)
        SC_PREFIX:   pc_d    = PREFIX_LOAD;
        SC_ALT_MK:   alt_d   = 1'b1;
        SC_ALT_BRK:  alt_d   = 1'b0;
        SC_CTRL_MK:  ctrl_d  = 1'b1;
        SC_CTRL_BRK: ctrl_d  = 1'b0;
        SC_RSH_MK:   shift_d = 1'b1;
        SC_RSH_BRK:  shift_d = 1'b0;
        SC_CAPS_MK:  caps_d  = 1'b1;
        SC_CAPS_BRK: caps_d  = 1'b0;
        // left shift is a fake shift while a prefix is live
        SC_LSH_MK: begin
          if (pc_dec == 2'd0) shift_d = 1'b1;
        end
        SC_LSH_BRK: begin
          if (pc_dec == 2'd0) shift_d = 1'b0;
        end
        SC_DELETE: begin
          reset_req_o = ctrl_q && alt_q;
          translate   = 1'b1;
        end
        default: translate = !scancode_i[7] && (scancode_i <= SC_LAST_KEY);
      endcase
    end
  end

  // Character: ctrl masks the plain value, caps swaps letter case
  always_comb begin
    base = kscdf_lookup(shift_q && !ctrl_q, scancode_i);
    ch   = base;
    if (ctrl_q) begin
      ch = base & CTRL_MASK;
    end else if (caps_q) begin
      if (base inside {[8'h41:8'h5A]}) begin
        ch = base + CASE_BIT;
      end else if (base inside {[8'h61:8'h7A]}) begin
        ch = base - CASE_BIT;
      end
    end
  end

  assign push_o.valid = translate;
  assign push_o.ch    = ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_q   <= 1'b0;
      ctrl_q  <= 1'b0;
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      pc_q    <= 2'd0;
    end else begin
      alt_q   <= alt_d;
      ctrl_q  <= ctrl_d;
      shift_q <= shift_d;
      caps_q  <= caps_d;
      pc_q    <= pc_d;
    end
  end

endmodule

>>> src/kscdf_ring.sv
// ----------------------------------------------------------------------------
// kscdf_ring
// Character ring in a synchronous memory; registered read, one access a beat.
// ----------------------------------------------------------------------------
module kscdf_ring import kscdf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  input  logic       pop_i,
  output logic       pop_hit_o,
  output logic       drop_o,
  output logic [7:0] rd_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] head_nxt, tail_nxt;
  logic             wr_en;
  logic [7:0]       rd_q;

  // Pointer wrap and full/empty
  always_comb begin
    head_nxt  = (head_q == LAST) ? '0 : (head_q + PTR_W'(1));
    tail_nxt  = (tail_q == LAST) ? '0 : (tail_q + PTR_W'(1));
    pop_hit_o = pop_i && (head_q != tail_q);
    wr_en     = push_i.valid && (tail_nxt != head_q);
    drop_o    = push_i.valid && (tail_nxt == head_q);
    head_d    = pop_hit_o ? head_nxt : head_q;
    tail_d    = wr_en ? tail_nxt : tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Storage; a read never hits the entry written in the same beat
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[tail_q] <= push_i.ch;
    if (pop_hit_o) rd_q <= mem_q[head_q];
  end

  assign rd_data_o = rd_q;

endmodule

>>> src/kscdf_outbuf.sv
// ----------------------------------------------------------------------------
// kscdf_outbuf
// Small result buffer that decouples the output stall from the input side.
// ----------------------------------------------------------------------------
module kscdf_outbuf import kscdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  result_t             wr_data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output result_t             data_o,
  output logic [OB_CNT_W-1:0] count_o
);

  result_t             buf_q [OB_DEPTH];
  logic [OB_PTR_W-1:0] wp_q, rp_q;
  logic [OB_CNT_W-1:0] cnt_q, cnt_d;
  logic                rd;

  assign valid_o = (cnt_q != '0);
  assign rd      = valid_o && !stall_i;
  assign data_o  = buf_q[rp_q];
  assign count_o = cnt_q;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd) cnt_d = cnt_q + OB_CNT_W'(1);
    if (!wr_i && rd) cnt_d = cnt_q - OB_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) wp_q <= wp_q + OB_PTR_W'(1);
      if (rd) rp_q <= rp_q + OB_PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) buf_q[wp_q] <= wr_data_i;
  end

endmodule

>>> src/keyboard_scancode_decoder_fifo_top.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_fifo_top
// Set-1 scancode translator with a character ring and read requests.
//
//   channel | direction | handshake              | fields
//   --------+-----------+------------------------+---------------------------
//   in      | to block  | in_valid_i/in_stall_o  | op, scancode
//   out     | from block| out_valid_o/out_stall_i| read_valid, read_char,
//           |           |                        | reset_request, key_dropped
//
// One beat per cycle in while in_stall_o is low, one result per beat. The
// accept cycle does lookup, flag update and the single ring access; the next
// cycle returns the registered memory read to the output buffer.
// Reset clears flags, prefix counter and ring pointers; ring storage is not
// cleared and needs no sweep. in_stall_o comes from registered occupancy of
// the four-entry output buffer, never directly from out_stall_i.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder_fifo_top import kscdf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] scancode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       read_valid_o,
  output logic [7:0] read_char_o,
  output logic       reset_request_o,
  output logic       key_dropped_o
);

  logic                in_beat;
  push_t               push;
  logic                reset_req;
  logic                pop_hit;
  logic                drop;
  logic [7:0]          rd_data;
  logic [OB_CNT_W-1:0] ob_count;
  result_t             res_b;
  result_t             res_out;

  logic b_valid_q;
  logic b_rvalid_q;
  logic b_req_q;
  logic b_drop_q;

  // Accept while the output buffer has room for everything in flight
  assign in_stall_o = ({1'b0, ob_count} + (OB_CNT_W + 1)'(b_valid_q))
                      >= (OB_CNT_W + 1)'(OB_DEPTH);
  assign in_beat    = in_valid_i && !in_stall_o;

  kscdf_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (in_beat && (op_i == OP_SCAN)),
    .scancode_i  (scancode_i),
    .push_o      (push),
    .reset_req_o (reset_req)
  );

  kscdf_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (in_beat && (op_i == OP_READ)),
    .pop_hit_o (pop_hit),
    .drop_o    (drop),
    .rd_data_o (rd_data)
  );

  // Read-return stage: waits on the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= in_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      b_rvalid_q <= pop_hit;
      b_req_q    <= reset_req;
      b_drop_q   <= drop;
    end
  end

  always_comb begin
    res_b.read_valid    = b_rvalid_q;
    res_b.read_char     = b_rvalid_q ? rd_data : 8'h00;
    res_b.reset_request = b_req_q;
    res_b.key_dropped   = b_drop_q;
  end

  kscdf_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (b_valid_q),
    .wr_data_i (res_b),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .data_o    (res_out),
    .count_o   (ob_count)
  );

  assign read_valid_o    = res_out.read_valid;
  assign read_char_o     = res_out.read_char;
  assign reset_request_o = res_out.reset_request;
  assign key_dropped_o   = res_out.key_dropped;

endmodule

>>> src/kscdf_checker.sv
// ----------------------------------------------------------------------------
// kscdf_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_decoder_fifo_top_assert.svh"

module kscdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       read_valid_o,
  input logic [7:0] read_char_o,
  input logic       reset_request_o,
  input logic       key_dropped_o
);

  // A stalled result beat holds
  `KSCDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_char_o) && $stable(read_valid_o), "result beat changed under stall")

  // A miss or a scancode beat carries a zero character
  `KSCDF_ASSERT_NOW(a_char_zero, clk_i, rst_ni, out_valid_o && !read_valid_o, read_char_o == 8'h00, "character without a queue hit")

  // A read result never carries scancode flags
  `KSCDF_ASSERT_NOW(a_read_flags, clk_i, rst_ni, out_valid_o && read_valid_o, !reset_request_o && !key_dropped_o, "read beat with scancode flags")

endmodule

bind keyboard_scancode_decoder_fifo_top kscdf_checker u_kscdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_valid_o    (read_valid_o),
  .read_char_o     (read_char_o),
  .reset_request_o (reset_request_o),
  .key_dropped_o   (key_dropped_o)
);

>>> dv/keyboard_scancode_decoder_fifo_top_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// keyboard_scancode_decoder_fifo_top_test
// Self-checking bench for the set-1 scancode decoder and its character ring.
// A short table of directed beats covers the modifiers, the extended prefix,
// ctrl+alt+del and an empty read. It is followed by a ring fill past full
// while the result side holds off, a long drain with no idling, and mixed key
// sequences with random content. Every result beat is checked field by field
// against an in-bench decoder model or a fixed expectation in the table.
// -----------------------------------------------------------------------------
module keyboard_scancode_decoder_fifo_top_test;
  import kscdf_pkg::*;

  localparam int unsigned RING_SIZE      = QUEUE_DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned IDLE_PCT       = 11;
  localparam int unsigned FILL_KEYS      = 280;
  localparam int unsigned DRAIN_READS    = 270;
  localparam int unsigned MIXED_BEATS    = 280;
  localparam int unsigned MIXED_READ_PCT = 40;
  localparam int unsigned DIR_N          = 25;

  typedef struct packed {
    logic       op;
    logic [7:0] sc;
  } key_beat_t;

  typedef struct packed {
    logic       op;
    logic [7:0] sc;
    logic       exact;
    result_t    want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  // Unshifted and shifted characters for make codes 0x00..0x39
  localparam logic [7:0] LOWER_KEYS [0:57] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h80, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h80, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h80, 8'h2A,
    8'h80, 8'h20
  };

  localparam logic [7:0] UPPER_KEYS [0:57] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h80, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h80, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h80, 8'h2A,
    8'h80, 8'h20
  };

  // Directed beats; want is only used where exact is set
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{OP_READ, 8'h00,       1'b1, NO_RESULT},                  // empty ring read
    '{OP_SCAN, 8'h00,       1'b1, NO_RESULT},                  // code 0 queues NUL
    '{OP_READ, 8'h5A,       1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
    '{OP_SCAN, 8'h1E,       1'b1, NO_RESULT},
    '{OP_READ, 8'hFF,       1'b1, '{1'b1, 8'h61, 1'b0, 1'b0}},
    '{OP_SCAN, SC_LSH_MK,   1'b0, NO_RESULT},
    '{OP_SCAN, 8'h02,       1'b0, NO_RESULT},
    '{OP_SCAN, SC_LSH_BRK,  1'b0, NO_RESULT},
    '{OP_SCAN, SC_CAPS_MK,  1'b0, NO_RESULT},
    '{OP_SCAN, 8'h10,       1'b0, NO_RESULT},                  // caps only
    '{OP_SCAN, SC_RSH_MK,   1'b0, NO_RESULT},
    '{OP_SCAN, 8'h10,       1'b0, NO_RESULT},                  // caps and shift
    '{OP_SCAN, SC_RSH_BRK,  1'b0, NO_RESULT},
    '{OP_SCAN, SC_CAPS_BRK, 1'b0, NO_RESULT},
    '{OP_SCAN, SC_PREFIX,   1'b0, NO_RESULT},
    '{OP_SCAN, SC_LSH_MK,   1'b0, NO_RESULT},                  // fake shift, ignored
    '{OP_SCAN, SC_LAST_KEY, 1'b0, NO_RESULT},
    '{OP_SCAN, SC_CTRL_MK,  1'b0, NO_RESULT},
    '{OP_SCAN, 8'h2E,       1'b0, NO_RESULT},                  // ctrl+c
    '{OP_SCAN, SC_ALT_MK,   1'b0, NO_RESULT},
    '{OP_SCAN, SC_DELETE,   1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}},
    '{OP_SCAN, SC_CTRL_BRK, 1'b0, NO_RESULT},
    '{OP_SCAN, SC_ALT_BRK,  1'b0, NO_RESULT},
    '{OP_SCAN, 8'hFF,       1'b1, NO_RESULT},                  // unknown break
    '{OP_SCAN, 8'h3B,       1'b1, NO_RESULT}                   // key past the table
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = OP_SCAN;
  logic [7:0] scancode_i  = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       read_valid_o;
  logic [7:0] read_char_o;
  logic       reset_request_o;
  logic       key_dropped_o;

  // Decoder model state
  logic        alt_held   = 1'b0;
  logic        ctrl_held  = 1'b0;
  logic        shift_held = 1'b0;
  logic        caps_held  = 1'b0;
  logic [1:0]  ext_left   = 2'd0;
  logic [7:0]  ring [RING_SIZE];
  int unsigned ring_rd    = 0;
  int unsigned ring_wr    = 0;

  key_beat_t key_beats[$];
  result_t   pending_results[$];
  int        error_count  = 0;
  bit        quiet_run    = 1'b0;
  bit        hold_off_req = 1'b0;

  keyboard_scancode_decoder_fifo_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .scancode_i      (scancode_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_valid_o    (read_valid_o),
    .read_char_o     (read_char_o),
    .reset_request_o (reset_request_o),
    .key_dropped_o   (key_dropped_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Character for a make code; Delete is the same in both maps
  function automatic logic [7:0] key_char(input logic upper, input logic [7:0] sc);
    if (sc == SC_DELETE) return CH_DELETE;
    return upper ? UPPER_KEYS[sc[5:0]] : LOWER_KEYS[sc[5:0]];
  endfunction

  // Advance the model by one beat and return the result it should produce
  function automatic result_t decode_beat(input logic op, input logic [7:0] sc);
    result_t     r;
    logic        xlate;
    logic [7:0]  ch;
    int unsigned nxt;
    r = NO_RESULT;
    xlate = 1'b0;
    if (op == OP_READ) begin
      if (ring_rd != ring_wr) begin
        r.read_valid = 1'b1;
        r.read_char  = ring[ring_rd];
        ring_rd = (ring_rd + 1) % RING_SIZE;
      end
      return r;
    end
    if (ext_left != 2'd0) ext_left = ext_left - 2'd1;
    case (sc)
      SC_PREFIX:   ext_left = PREFIX_LOAD;
      SC_ALT_MK:   alt_held = 1'b1;
      SC_ALT_BRK:  alt_held = 1'b0;
      SC_CTRL_MK:  ctrl_held = 1'b1;
      SC_CTRL_BRK: ctrl_held = 1'b0;
      SC_LSH_MK:   if (ext_left == 2'd0) shift_held = 1'b1;
      SC_LSH_BRK:  if (ext_left == 2'd0) shift_held = 1'b0;
      SC_RSH_MK:   shift_held = 1'b1;
      SC_RSH_BRK:  shift_held = 1'b0;
      SC_CAPS_MK:  caps_held = 1'b1;
      SC_CAPS_BRK: caps_held = 1'b0;
      SC_DELETE: begin
        r.reset_request = ctrl_held && alt_held;
        xlate = 1'b1;
      end
      default:     xlate = (sc <= SC_LAST_KEY);
    endcase
    if (xlate) begin
      if (ctrl_held) begin
        ch = key_char(1'b0, sc) & CTRL_MASK;
      end else begin
        ch = key_char(shift_held, sc);
        if (caps_held && ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")))
          ch = ch ^ CASE_BIT;
      end
      nxt = (ring_wr + 1) % RING_SIZE;
      if (nxt != ring_rd) begin
        ring[ring_wr] = ch;
        ring_wr = nxt;
      end else begin
        r.key_dropped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void add_beat(input logic op, input logic [7:0] sc);
    key_beats.push_back('{op, sc});
  endfunction

  // Mostly printable keys, now and then Delete
  function automatic logic [7:0] random_key();
    if ($urandom_range(0, 9) == 0) return SC_DELETE;
    return 8'($urandom_range(0, SC_LAST_KEY));
  endfunction

  // Well-formed key sequences with random content, some reads and some noise
  function automatic void add_traffic(input int unsigned n, input int unsigned read_pct);
    int unsigned goal;
    int unsigned roll;
    logic        use_left;
    goal = key_beats.size() + n;
    while (key_beats.size() < goal) begin
      if ($urandom_range(0, 99) < read_pct) begin
        repeat ($urandom_range(1, 3)) add_beat(OP_READ, 8'($urandom_range(0, 255)));
        continue;
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        add_beat(OP_SCAN, random_key());
      end else if (roll < 60) begin
        // shifted run on either shift key
        use_left = 1'($urandom_range(0, 1));
        add_beat(OP_SCAN, use_left ? SC_LSH_MK : SC_RSH_MK);
        repeat ($urandom_range(1, 4)) add_beat(OP_SCAN, random_key());
        add_beat(OP_SCAN, use_left ? SC_LSH_BRK : SC_RSH_BRK);
      end else if (roll < 70) begin
        add_beat(OP_SCAN, $urandom_range(0, 1) ? SC_CAPS_MK : SC_CAPS_BRK);
      end else if (roll < 78) begin
        add_beat(OP_SCAN, SC_CTRL_MK);
        repeat ($urandom_range(1, 3)) add_beat(OP_SCAN, random_key());
        add_beat(OP_SCAN, SC_CTRL_BRK);
      end else if (roll < 85) begin
        // three-finger salute, sometimes without ctrl
        if ($urandom_range(0, 3) != 0) add_beat(OP_SCAN, SC_CTRL_MK);
        add_beat(OP_SCAN, SC_ALT_MK);
        add_beat(OP_SCAN, SC_DELETE);
        add_beat(OP_SCAN, SC_ALT_BRK);
        add_beat(OP_SCAN, SC_CTRL_BRK);
      end else if (roll < 93) begin
        // extended prefix, then a fake shift or any byte, then a key
        add_beat(OP_SCAN, SC_PREFIX);
        case ($urandom_range(0, 2))
          0:       add_beat(OP_SCAN, SC_LSH_MK);
          1:       add_beat(OP_SCAN, SC_LSH_BRK);
          default: add_beat(OP_SCAN, 8'($urandom_range(0, 255)));
        endcase
        add_beat(OP_SCAN, random_key());
      end else begin
        add_beat(OP_SCAN, 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Offer one beat, with random idle cycles first; returns after acceptance
  task automatic send_beat(input logic op, input logic [7:0] sc, output result_t r);
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    scancode_i <= sc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = decode_beat(op, sc);
  endtask

  task automatic play_beats();
    key_beat_t b;
    result_t   r;
    while (key_beats.size() != 0) begin
      b = key_beats.pop_front();
      send_beat(b.op, b.sc, r);
      pending_results.push_back(r);
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result side: random stall, a quiet stretch, and one long hold-off
  initial begin : result_stall
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= !quiet_run && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %b %h %b %b", $time,
                 read_valid_o, read_char_o, reset_request_o, key_dropped_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_valid", 8'(want.read_valid), 8'(read_valid_o));
        check_field("read_char", want.read_char, read_char_o);
        check_field("reset_request", 8'(want.reset_request), 8'(reset_request_o));
        check_field("key_dropped", 8'(want.key_dropped), 8'(key_dropped_o));
      end
    end
  end

  // Ends the run if no beat moves on either side for too long
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    @(posedge rst_ni);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    result_t predicted;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].op, DIRECTED[i].sc, predicted);
      pending_results.push_back(DIRECTED[i].exact ? DIRECTED[i].want : predicted);
    end

    // Overfill the ring while the result side holds off
    hold_off_req = 1'b1;
    repeat (FILL_KEYS) add_beat(OP_SCAN, random_key());
    add_beat(OP_SCAN, SC_CTRL_MK);
    add_beat(OP_SCAN, SC_ALT_MK);
    add_beat(OP_SCAN, SC_DELETE);
    add_beat(OP_SCAN, SC_ALT_BRK);
    add_beat(OP_SCAN, SC_CTRL_BRK);
    play_beats();

    // Drain past empty with no idling on either side
    quiet_run = 1'b1;
    repeat (DRAIN_READS) add_beat(OP_READ, 8'($urandom_range(0, 255)));
    play_beats();
    quiet_run = 1'b0;

    add_traffic(MIXED_BEATS, MIXED_READ_PCT);
    play_beats();
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
